### src/bfa_pkg.sv
// Shared types, constants and mask helpers for the bitmap frame allocator.
// Used by bfa_scan and bitmap_frame_allocator_core; no dependencies.
package bfa_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int BATCH      = 8;
  localparam int FRAME_W    = 16;
  localparam int CNT_W      = 17;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int MAP_DEPTH  = MAX_FRAMES / WORD_W;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int WIDX_W     = CNT_W - BIT_W;
  localparam int BATCH_AW   = (BATCH > 1) ? $clog2(BATCH) : 1;
  localparam int BCNT_W     = $clog2(BATCH + 1);
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WORD_W-1:0] ALL_USED = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FREED   = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FAULT   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL    = 1'd0,
    CFG_RESERVED = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_REF_RD,
    S_REF_CHK,
    S_BRD,
    S_BWAIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_pos;
    logic             last;
  } scan_res_t;

  // bits of word w whose frame index is at or above lim
  function automatic logic [WORD_W-1:0] ge_mask(input logic [MAP_AW-1:0] w,
                                                input logic [CNT_W-1:0] lim);
    logic [WIDX_W-1:0] wx;
    logic [WIDX_W-1:0] lw;
    logic [WORD_W-1:0] m;
    wx = WIDX_W'(w);
    lw = lim[CNT_W-1:BIT_W];
    if (wx > lw) begin
      m = '1;
    end else if (wx == lw) begin
      m = ALL_USED << lim[BIT_W-1:0];
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

### src/bfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bfa_scan.sv
// Lowest-free search within one bitmap word, bounded by start and managed count.
// Depends on bfa_pkg.
module bfa_scan (
  input  logic [bfa_pkg::WORD_W-1:0] data,
  input  logic [bfa_pkg::MAP_AW-1:0] word,
  input  logic [bfa_pkg::CNT_W-1:0]  start,
  input  logic [bfa_pkg::CNT_W-1:0]  limit,
  output bfa_pkg::scan_res_t         res
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] cand;
  logic [CNT_W-1:0]  next_base;

  assign cand      = ~data & ge_mask(word, start) & ~ge_mask(word, limit);
  assign next_base = {WIDX_W'(word) + WIDX_W'(1), BIT_W'(0)};

  always_comb begin
    res.found   = |cand;
    res.bit_pos = '0;
    res.last    = (next_base >= limit);
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.bit_pos = BIT_W'(i);
      end
    end
  end

endmodule

### src/bitmap_frame_allocator_core.sv
// Bitmap frame allocator top: request sequencer, bitmap and batch RAMs.
// Depends on bfa_pkg, bfa_ram, bfa_scan.
// A free reads and updates one bitmap word; a buffered alloc reads the batch
// RAM; a refill alloc marks frames used and scans for the next free one; init
// writes all 2048 bitmap words, then scans for the hint. One request in flight.
// Reset: a pass writes every bitmap word all used; no request taken meanwhile.
module bitmap_frame_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bfa_pkg::FRAME_W-1:0]     s_axis_tdata,   // frame_number
  input  logic [bfa_pkg::FUNC_W-1:0]      s_axis_tuser,   // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bfa_pkg::FRAME_W-1:0]     m_axis_tdata,   // frame_number_out
  output logic [bfa_pkg::STATUS_W-1:0]    m_axis_tuser,   // status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfa_pkg::CNT_W-1:0]       cfg_data
);
  import bfa_pkg::*;

  state_t                state, state_next;
  logic [MAP_AW-1:0]     cnt, cnt_next;
  logic [MAP_AW-1:0]     scan_word, scan_word_next;
  logic [CNT_W-1:0]      scan_pos, scan_pos_next;
  logic [CNT_W-1:0]      hint, hint_next;
  logic [BCNT_W-1:0]     batch_index, batch_index_next;
  logic [BCNT_W-1:0]     ref_cnt, ref_cnt_next;
  logic                  fault, fault_next;
  func_t                 func_q, func_q_next;
  logic [FRAME_W-1:0]    fnum_q, fnum_q_next;
  logic [FRAME_W-1:0]    res_frame, res_frame_next;
  status_t               res_status, res_status_next;
  logic [CNT_W-1:0]      total_frames, reserved_frames, n;

  logic                  map_we;
  logic [MAP_AW-1:0]     map_waddr, map_raddr;
  logic [WORD_W-1:0]     map_wdata, map_rdata;
  logic                  b_we;
  logic [BATCH_AW-1:0]   b_waddr, b_raddr;
  logic [FRAME_W-1:0]    b_wdata, b_rdata;
  scan_res_t             scan;
  logic                  s_fire, out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign n = (total_frames > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : total_frames;

  bfa_ram #(.WIDTH(WORD_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  bfa_ram #(.WIDTH(FRAME_W), .DEPTH(BATCH)) u_batch (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  bfa_scan u_scan (
    .data(map_rdata), .word(scan_word), .start(scan_pos), .limit(n), .res(scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames    <= '0;
      reserved_frames <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL:    total_frames    <= cfg_data;
        CFG_RESERVED: reserved_frames <= cfg_data;
        default:      total_frames    <= total_frames;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (cnt == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (s_fire) begin
          if (func_t'(s_axis_tuser) == FN_INIT) begin
            state_next = S_INIT;
          end else if (fault) begin
            state_next = S_DONE;
          end else if (func_t'(s_axis_tuser) == FN_ALLOC) begin
            state_next = (batch_index >= BCNT_W'(BATCH)) ? S_REF_RD : S_BRD;
          end else if (func_t'(s_axis_tuser) == FN_FREE
                       && CNT_W'(s_axis_tdata) < n) begin
            state_next = S_FREE_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_INIT: begin
        if (cnt == '1) state_next = (n == '0) ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (scan.found || scan.last) begin
          if (func_q == FN_INIT) begin
            state_next = S_DONE;
          end else if (ref_cnt == BCNT_W'(BATCH)) begin
            state_next = S_BRD;
          end else begin
            state_next = S_REF_RD;
          end
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_REF_RD:   state_next = (hint >= n) ? S_DONE : S_REF_CHK;
      S_REF_CHK:  state_next = map_rdata[hint[BIT_W-1:0]] ? S_DONE : S_SCAN_RD;
      S_BRD:      state_next = S_BWAIT;
      S_BWAIT:    state_next = S_DONE;
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_next         = cnt;
    scan_word_next   = scan_word;
    scan_pos_next    = scan_pos;
    hint_next        = hint;
    batch_index_next = batch_index;
    ref_cnt_next     = ref_cnt;
    fault_next       = fault;
    func_q_next      = func_q;
    fnum_q_next      = fnum_q;
    res_frame_next   = res_frame;
    res_status_next  = res_status;
    map_we           = 1'b0;
    map_waddr        = cnt;
    map_wdata        = ALL_USED;
    map_raddr        = scan_word;
    b_we             = 1'b0;
    b_waddr          = ref_cnt[BATCH_AW-1:0];
    b_wdata          = hint[FRAME_W-1:0];
    b_raddr          = batch_index[BATCH_AW-1:0];
    case (state)
      S_CLEAR: begin
        map_we   = 1'b1;
        cnt_next = cnt + MAP_AW'(1);
      end
      S_IDLE: begin
        if (s_fire) begin
          func_q_next     = func_t'(s_axis_tuser);
          fnum_q_next     = s_axis_tdata;
          res_frame_next  = '0;
          res_status_next = ST_IGNORED;
          cnt_next        = '0;
          ref_cnt_next    = '0;
          if (func_t'(s_axis_tuser) == FN_INIT) begin
            res_status_next  = ST_OK;
            batch_index_next = BCNT_W'(BATCH);
            fault_next       = 1'b0;
          end else if (fault) begin
            res_status_next = ST_FAULT;
          end
        end
      end
      S_INIT: begin
        map_we         = 1'b1;
        map_wdata      = ~(ge_mask(cnt, reserved_frames) & ~ge_mask(cnt, n));
        cnt_next       = cnt + MAP_AW'(1);
        scan_word_next = '0;
        scan_pos_next  = '0;
        hint_next      = '0;
      end
      S_SCAN_CHK: begin
        if (scan.found) begin
          hint_next = {WIDX_W'(scan_word), scan.bit_pos};
        end else if (scan.last) begin
          hint_next = n;
        end else begin
          scan_word_next = scan_word + MAP_AW'(1);
          scan_pos_next  = {WIDX_W'(scan_word) + WIDX_W'(1), BIT_W'(0)};
        end
        if ((scan.found || scan.last) && func_q != FN_INIT
            && ref_cnt == BCNT_W'(BATCH)) begin
          batch_index_next = '0;
        end
      end
      S_REF_RD: begin
        map_raddr = hint[CNT_W-2:BIT_W];
        if (hint >= n) begin
          fault_next      = 1'b1;
          res_status_next = ST_FAULT;
        end
      end
      S_REF_CHK: begin
        if (map_rdata[hint[BIT_W-1:0]]) begin
          fault_next      = 1'b1;
          res_status_next = ST_FAULT;
        end else begin
          b_we           = 1'b1;
          map_we         = 1'b1;
          map_waddr      = hint[CNT_W-2:BIT_W];
          map_wdata      = map_rdata | (WORD_W'(1) << hint[BIT_W-1:0]);
          ref_cnt_next   = ref_cnt + BCNT_W'(1);
          scan_word_next = hint[CNT_W-2:BIT_W];
          scan_pos_next  = hint;
        end
      end
      S_BWAIT: begin
        res_frame_next   = b_rdata;
        res_status_next  = ST_OK;
        batch_index_next = batch_index + BCNT_W'(1);
      end
      S_FREE_RD: begin
        map_raddr = fnum_q[FRAME_W-1:BIT_W];
      end
      S_FREE_CHK: begin
        if (map_rdata[fnum_q[BIT_W-1:0]]) begin
          map_we          = 1'b1;
          map_waddr       = fnum_q[FRAME_W-1:BIT_W];
          map_wdata       = map_rdata & ~(WORD_W'(1) << fnum_q[BIT_W-1:0]);
          res_status_next = ST_FREED;
          if (CNT_W'(fnum_q) < hint) hint_next = CNT_W'(fnum_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      hint          <= '0;
      batch_index   <= BCNT_W'(BATCH);
      ref_cnt       <= '0;
      fault         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      hint        <= hint_next;
      batch_index <= batch_index_next;
      ref_cnt     <= ref_cnt_next;
      fault       <= fault_next;
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_word  <= scan_word_next;
    scan_pos   <= scan_pos_next;
    func_q     <= func_q_next;
    fnum_q     <= fnum_q_next;
    res_frame  <= res_frame_next;
    res_status <= res_status_next;
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= res_frame;
      m_axis_tuser <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_batch_bound: assert property (@(posedge clk) disable iff (rst)
    batch_index <= BCNT_W'(BATCH))
    else $error("batch index past batch size");
  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    hint <= CNT_W'(MAX_FRAMES))
    else $error("hint beyond frame space");
  a_bread_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_BWAIT |-> batch_index < BCNT_W'(BATCH))
    else $error("batch read of spent buffer");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> state != S_IDLE)
    else $error("request accepted without processing");
  a_fault_no_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_FAULT |-> m_axis_tdata == '0)
    else $error("fault result carries a frame");
`endif

endmodule
